FILE: hw/rtl/abt_pkg.sv
// ----------------------------------------------------------------------------
// abt_pkg: shared types, constants and arithmetic helpers of the tracker
// Fixed point coordinates at 1/1024 m, gains at 1/256.
// ----------------------------------------------------------------------------
`default_nettype none

package abt_pkg;

  localparam int CoordBits = 16;
  localparam int WideBits  = CoordBits + 13;
  localparam int DistBits  = 2 * CoordBits + 2;
  localparam int GainBits  = 9;
  localparam int GateBits  = 32;
  localparam int MissBits  = 4;
  localparam int QDepth    = 4;
  localparam int QPtrBits  = $clog2(QDepth);
  localparam int QCntBits  = $clog2(QDepth + 1);
  localparam int AddrBits  = 5;
  localparam int DataBits  = 32;
  localparam int RegIdxBits = 3;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [WideBits-1:0]  wide_t;
  typedef logic [DistBits-1:0]         dist_t;
  typedef logic [GainBits-1:0]         gain_t;
  typedef logic [MissBits-1:0]         miss_t;

  // operation codes carried through the queue
  typedef logic [1:0] op_t;
  localparam op_t OP_POINT      = 2'd0;
  localparam op_t OP_POINT_LAST = 2'd1;
  localparam op_t OP_END        = 2'd2;

  // register indexes
  localparam logic [RegIdxBits-1:0] REG_POS_GAIN  = 3'd0;
  localparam logic [RegIdxBits-1:0] REG_VEL_GAIN  = 3'd1;
  localparam logic [RegIdxBits-1:0] REG_DECAY     = 3'd2;
  localparam logic [RegIdxBits-1:0] REG_GATE      = 3'd3;
  localparam logic [RegIdxBits-1:0] REG_MISS_LIM  = 3'd4;

  localparam gain_t RstPosGain = 9'd154;
  localparam gain_t RstVelGain = 9'd26;
  localparam gain_t RstDecay   = 9'd230;
  localparam logic [GateBits-1:0] RstGate = 32'd262144;
  localparam miss_t RstMissLim = 4'd10;
  localparam miss_t MissMax    = 4'd15;

  localparam wide_t CoordMaxW = WideBits'((64'sd1 <<< (CoordBits - 1)) - 64'sd1);
  localparam wide_t CoordMinW = -CoordMaxW - WideBits'(1);
  localparam wide_t RoundHalf = WideBits'(128);

  typedef struct packed {
    op_t    op;
    coord_t x;
    coord_t y;
    coord_t self_x;
    coord_t self_y;
  } q_entry_t;

  typedef struct packed {
    gain_t               pos_gain;
    gain_t               vel_gain;
    gain_t               decay;
    logic [GateBits-1:0] gate;
    miss_t               miss_limit;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic wide_t widen(input coord_t v);
    return WideBits'(v);
  endfunction

  function automatic coord_t sat_coord(input wide_t v);
    wide_t t;
    t = v;
    if (v > CoordMaxW) t = CoordMaxW;
    else if (v < CoordMinW) t = CoordMinW;
    return t[CoordBits-1:0];
  endfunction

  // floor((p + 128) / 256)
  function automatic wide_t round_gain(input wide_t p);
    return (p + RoundHalf) >>> 8;
  endfunction

  function automatic wide_t gain_mul(input gain_t g, input wide_t d);
    wide_t gw;
    gw = WideBits'(signed'({1'b0, g}));
    return gw * d;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/abt_front.sv
// ----------------------------------------------------------------------------
// abt_front: input stage
// Accepts items, classifies them into queue operations and pushes them.
// ----------------------------------------------------------------------------
`default_nettype none

module abt_front
  import abt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     has_point,
  input  wire coord_t   point_x,
  input  wire coord_t   point_y,
  input  wire logic     last_of_frame,
  input  wire coord_t   self_x,
  input  wire coord_t   self_y,
  input  wire q_status_t q_status,
  output logic          push,
  output q_entry_t      push_entry
);

  logic     held;
  q_entry_t entry;
  op_t      op_next;

  assign in_stall   = held && q_status.full;
  assign push       = held && !q_status.full;
  assign push_entry = entry;

  always_comb begin
    if (!has_point) op_next = OP_END;
    else if (last_of_frame) op_next = OP_POINT_LAST;
    else op_next = OP_POINT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      entry.op     <= op_next;
      entry.x      <= point_x;
      entry.y      <= point_y;
      entry.self_x <= self_x;
      entry.self_y <= self_y;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/abt_queue.sv
// ----------------------------------------------------------------------------
// abt_queue: operation queue
// Short register queue between the input stage and the execution stage.
// ----------------------------------------------------------------------------
`default_nettype none

module abt_queue
  import abt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  input  wire logic     pop,
  output q_entry_t      head,
  output q_status_t     status
);

  q_entry_t              slots [QDepth];
  logic [QPtrBits-1:0]   wptr;
  logic [QPtrBits-1:0]   rptr;
  logic [QCntBits-1:0]   count;

  assign head         = slots[rptr];
  assign status.full  = (count == QCntBits'(QDepth));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_entry;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/abt_back.sv
// ----------------------------------------------------------------------------
// abt_back: execution stage
// Keeps the best point of the open frame, runs the frame-end update and
// holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module abt_back
  import abt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire q_entry_t  head,
  input  wire q_status_t q_status,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output logic           target_valid,
  output coord_t         estimate_x,
  output coord_t         estimate_y,
  output coord_t         estimate_vx,
  output coord_t         estimate_vy
);

  // tracker state
  logic   track_active;
  logic   frame_open;
  logic   close_pend;
  miss_t  miss_count;
  coord_t est_x, est_y, est_vx, est_vy;
  coord_t best_x, best_y;
  dist_t  best_d;

  logic   track_active_next, frame_open_next, close_pend_next;
  miss_t  miss_count_next;
  coord_t est_x_next, est_y_next, est_vx_next, est_vy_next;
  logic   take_point;

  logic   slot_ok, head_ok, is_point, is_end;
  logic   do_close, do_empty, emit, emit_valid;

  logic signed [CoordBits:0]     ref_x, ref_y, dx, dy;
  logic signed [2*CoordBits+1:0] sqx, sqy;
  dist_t                         pt_dist;

  wide_t  px, py, nx, ny, nvx, nvy;
  miss_t  miss_inc;
  logic   gate_miss;

  assign slot_ok  = !out_valid || !out_stall;
  assign head_ok  = !q_status.empty && !close_pend;
  assign is_point = (head.op == OP_POINT) || (head.op == OP_POINT_LAST);
  assign is_end   = (head.op == OP_END);

  // squared distance of the head point to the estimate or own pose
  always_comb begin
    ref_x   = track_active ? (CoordBits+1)'(est_x) : (CoordBits+1)'(head.self_x);
    ref_y   = track_active ? (CoordBits+1)'(est_y) : (CoordBits+1)'(head.self_y);
    dx      = (CoordBits+1)'(head.x) - ref_x;
    dy      = (CoordBits+1)'(head.y) - ref_y;
    sqx     = (2*CoordBits+2)'(dx) * (2*CoordBits+2)'(dx);
    sqy     = (2*CoordBits+2)'(dy) * (2*CoordBits+2)'(dy);
    pt_dist = dist_t'(sqx) + dist_t'(sqy);
  end

  // frame-end arithmetic
  always_comb begin
    px  = widen(est_x) + widen(est_vx);
    py  = widen(est_y) + widen(est_vy);
    nx  = px + round_gain(gain_mul(cfg.pos_gain, widen(best_x) - px));
    ny  = py + round_gain(gain_mul(cfg.pos_gain, widen(best_y) - py));
    nvx = widen(est_vx) + round_gain(gain_mul(cfg.vel_gain,
            widen(best_x) - widen(est_x) - widen(est_vx)));
    nvy = widen(est_vy) + round_gain(gain_mul(cfg.vel_gain,
            widen(best_y) - widen(est_y) - widen(est_vy)));
    miss_inc  = (miss_count == MissMax) ? MissMax : miss_count + 1'b1;
    gate_miss = best_d > DistBits'(cfg.gate);
  end

  always_comb begin
    do_close = close_pend ? slot_ok : (head_ok && is_end && frame_open && slot_ok);
    do_empty = head_ok && is_end && !frame_open && slot_ok;
    pop      = (head_ok && is_point) || (head_ok && is_end && slot_ok);
    take_point = head_ok && is_point && (!frame_open || pt_dist < best_d);

    track_active_next = track_active;
    frame_open_next   = frame_open;
    close_pend_next   = close_pend;
    miss_count_next   = miss_count;
    est_x_next  = est_x;
    est_y_next  = est_y;
    est_vx_next = est_vx;
    est_vy_next = est_vy;
    emit        = 1'b0;
    emit_valid  = 1'b0;

    if (head_ok && is_point) begin
      frame_open_next = 1'b1;
      close_pend_next = (head.op == OP_POINT_LAST);
    end

    if (do_close) begin
      frame_open_next = 1'b0;
      close_pend_next = 1'b0;
      if (!track_active) begin
        // track start, no transfer
        track_active_next = 1'b1;
        miss_count_next   = '0;
        est_x_next  = best_x;
        est_y_next  = best_y;
        est_vx_next = '0;
        est_vy_next = '0;
      end else if (gate_miss) begin
        miss_count_next = miss_inc;
        emit = 1'b1;
      end else begin
        miss_count_next = '0;
        est_x_next  = sat_coord(nx);
        est_y_next  = sat_coord(ny);
        est_vx_next = sat_coord(nvx);
        est_vy_next = sat_coord(nvy);
        emit       = 1'b1;
        emit_valid = 1'b1;
      end
    end

    if (do_empty) begin
      emit = 1'b1;
      if (track_active) begin
        miss_count_next = miss_inc;
        if (miss_inc < cfg.miss_limit) begin
          // coast with decaying velocity
          est_x_next  = sat_coord(widen(est_x) + widen(est_vx));
          est_y_next  = sat_coord(widen(est_y) + widen(est_vy));
          est_vx_next = sat_coord(round_gain(gain_mul(cfg.decay, widen(est_vx))));
          est_vy_next = sat_coord(round_gain(gain_mul(cfg.decay, widen(est_vy))));
          emit_valid  = 1'b1;
        end else begin
          track_active_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      track_active <= 1'b0;
      frame_open   <= 1'b0;
      close_pend   <= 1'b0;
      miss_count   <= '0;
      est_x        <= '0;
      est_y        <= '0;
      est_vx       <= '0;
      est_vy       <= '0;
      best_x       <= '0;
      best_y       <= '0;
      best_d       <= '0;
      out_valid    <= 1'b0;
    end else begin
      track_active <= track_active_next;
      frame_open   <= frame_open_next;
      close_pend   <= close_pend_next;
      miss_count   <= miss_count_next;
      est_x        <= est_x_next;
      est_y        <= est_y_next;
      est_vx       <= est_vx_next;
      est_vy       <= est_vy_next;
      if (take_point) begin
        best_x <= head.x;
        best_y <= head.y;
        best_d <= pt_dist;
      end
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      target_valid <= emit_valid;
      estimate_x   <= est_x_next;
      estimate_y   <= est_y_next;
      estimate_vx  <= est_vx_next;
      estimate_vy  <= est_vy_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/alpha_beta_target_tracker.sv
// Path: a result passes the input register, a queue slot and the result register after
// its item is accepted; when the frame ends on a point, the best-point update and the
// frame-end update run in turn. Throughput: one item per cycle while the input is not
// stalled; a point that ends a frame holds the execution stage, so back-to-back single-point frames run slower.
// Reset: synchronous, clears the track, the queue and the output register
// and loads the register defaults.
// ----------------------------------------------------------------------------
// alpha_beta_target_tracker: single-target alpha-beta tracker
// Register port, input stage, operation queue and execution stage.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_beta_target_tracker
  import abt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [DataBits-1:0] pwdata,
  output logic      [DataBits-1:0] prdata,
  output logic                     pready,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                has_point,
  input  wire coord_t              point_x,
  input  wire coord_t              point_y,
  input  wire logic                last_of_frame,
  input  wire coord_t              self_x,
  input  wire coord_t              self_y,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     target_valid,
  output coord_t                   estimate_x,
  output coord_t                   estimate_y,
  output coord_t                   estimate_vx,
  output coord_t                   estimate_vy
);

  cfg_t                  cfg;
  logic [RegIdxBits-1:0] reg_idx;
  logic                  wr_en;
  logic                  push;
  logic                  pop;
  q_entry_t              push_entry;
  q_entry_t              head;
  q_status_t             q_status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrBits-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_gain   <= RstPosGain;
      cfg.vel_gain   <= RstVelGain;
      cfg.decay      <= RstDecay;
      cfg.gate       <= RstGate;
      cfg.miss_limit <= RstMissLim;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_POS_GAIN: cfg.pos_gain   <= pwdata[GainBits-1:0];
        REG_VEL_GAIN: cfg.vel_gain   <= pwdata[GainBits-1:0];
        REG_DECAY:    cfg.decay      <= pwdata[GainBits-1:0];
        REG_GATE:     cfg.gate       <= pwdata[GateBits-1:0];
        REG_MISS_LIM: cfg.miss_limit <= pwdata[MissBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POS_GAIN: prdata = DataBits'(cfg.pos_gain);
      REG_VEL_GAIN: prdata = DataBits'(cfg.vel_gain);
      REG_DECAY:    prdata = DataBits'(cfg.decay);
      REG_GATE:     prdata = DataBits'(cfg.gate);
      REG_MISS_LIM: prdata = DataBits'(cfg.miss_limit);
      default:      prdata = '0;
    endcase
  end

  abt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .has_point     (has_point),
    .point_x       (point_x),
    .point_y       (point_y),
    .last_of_frame (last_of_frame),
    .self_x        (self_x),
    .self_y        (self_y),
    .q_status      (q_status),
    .push          (push),
    .push_entry    (push_entry)
  );

  abt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  abt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .target_valid (target_valid),
    .estimate_x   (estimate_x),
    .estimate_y   (estimate_y),
    .estimate_vx  (estimate_vx),
    .estimate_vy  (estimate_vy)
  );

  // never pop an empty queue
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_status.empty)
    else $error("pop from empty queue");

  assert property (@(posedge clk) disable iff (rst) !(q_status.full && q_status.empty))
    else $error("queue full and empty");

  // input stalls only when the queue is full
  assert property (@(posedge clk) disable iff (rst) in_stall |-> q_status.full)
    else $error("input stall without full queue");

  // a held result is not dropped
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled transfer lost");

  assert property (@(posedge clk) (!rst && $past(rst)) |-> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

FILE: sim/abt_track_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// abt_track_checker: predictor and result check for the alpha-beta tracker
// Watches the register port and both item channels, keeps its own copy of the
// track state and settings, and compares every result transfer in order.
// ----------------------------------------------------------------------------

module abt_track_checker
  import abt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic                pready,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [DataBits-1:0] pwdata,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire logic                has_point,
  input  wire coord_t              point_x,
  input  wire coord_t              point_y,
  input  wire logic                last_of_frame,
  input  wire coord_t              self_x,
  input  wire coord_t              self_y,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire logic                target_valid,
  input  wire coord_t              estimate_x,
  input  wire coord_t              estimate_y,
  input  wire coord_t              estimate_vx,
  input  wire coord_t              estimate_vy,
  output int                       fail_count,
  output int                       pending,
  output int                       results_checked,
  output int                       live_checked,
  output int                       tracks_started
);

  localparam longint CoordHi = (longint'(1) <<< (CoordBits - 1)) - 1;
  localparam longint CoordLo = -CoordHi - 1;

  typedef struct {
    logic   live;
    coord_t x;
    coord_t y;
    coord_t vx;
    coord_t vy;
  } estimate_t;

  estimate_t estimate_q[$];

  // settings as last written
  longint alpha, beta, decay, gate, miss_lim;

  // track state
  logic   tracking, frame_open;
  longint pos_x, pos_y, vel_x, vel_y;
  longint best_x, best_y, best_d;
  int     misses;

  int errors = 0;
  int n_results = 0;
  int n_live = 0;
  int n_starts = 0;

  function automatic longint clip(input longint v);
    if (v > CoordHi) return CoordHi;
    if (v < CoordLo) return CoordLo;
    return v;
  endfunction

  // floor((p + 128) / 256)
  function automatic longint gain_round(input longint p);
    return (p + 128) >>> 8;
  endfunction

  function automatic longint range_sq(input longint ax, ay, bx, by);
    return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic post_estimate(input logic live);
    estimate_t e;
    e.live = live;
    e.x = coord_t'(pos_x);
    e.y = coord_t'(pos_y);
    e.vx = coord_t'(vel_x);
    e.vy = coord_t'(vel_y);
    estimate_q = {estimate_q, e};
  endtask

  task automatic count_miss();
    if (misses < MissMax) misses++;
  endtask

  task automatic end_frame();
    longint px, py, ovx, ovy;
    frame_open = 1'b0;
    if (!tracking) begin
      pos_x = best_x;
      pos_y = best_y;
      vel_x = 0;
      vel_y = 0;
      tracking = 1'b1;
      misses = 0;
      n_starts++;
    end else if (best_d > gate) begin
      count_miss();
      post_estimate(1'b0);
    end else begin
      px = pos_x + vel_x;
      py = pos_y + vel_y;
      ovx = best_x - pos_x;
      ovy = best_y - pos_y;
      pos_x = clip(px + gain_round(alpha * (best_x - px)));
      pos_y = clip(py + gain_round(alpha * (best_y - py)));
      vel_x = clip(vel_x + gain_round(beta * (ovx - vel_x)));
      vel_y = clip(vel_y + gain_round(beta * (ovy - vel_y)));
      misses = 0;
      post_estimate(1'b1);
    end
  endtask

  task automatic take_item(input logic hp, input coord_t px, py, input logic last,
                           input coord_t sx, sy);
    longint x, y, d;
    x = px;
    y = py;
    if (hp) begin
      // nearest to the estimate once tracking, else nearest to own position
      if (tracking) d = range_sq(x, y, pos_x, pos_y);
      else d = range_sq(x, y, sx, sy);
      if (!frame_open || d < best_d) begin
        best_x = x;
        best_y = y;
        best_d = d;
      end
      frame_open = 1'b1;
      if (last) end_frame();
    end else if (frame_open) begin
      end_frame();
    end else if (!tracking) begin
      post_estimate(1'b0);
    end else begin
      count_miss();
      if (misses < miss_lim) begin
        pos_x = clip(pos_x + vel_x);
        pos_y = clip(pos_y + vel_y);
        vel_x = clip(gain_round(decay * vel_x));
        vel_y = clip(gain_round(decay * vel_y));
        post_estimate(1'b1);
      end else begin
        tracking = 1'b0;
        post_estimate(1'b0);
      end
    end
  endtask

  task automatic set_register(input logic [RegIdxBits-1:0] idx, input logic [DataBits-1:0] v);
    case (idx)
      REG_POS_GAIN: alpha = v[GainBits-1:0];
      REG_VEL_GAIN: beta = v[GainBits-1:0];
      REG_DECAY:    decay = v[GainBits-1:0];
      REG_GATE:     gate = v[GateBits-1:0];
      REG_MISS_LIM: miss_lim = v[MissBits-1:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [CoordBits-1:0] want, got);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s expected %0d got %0d",
                                n_results, name, $signed(want), $signed(got)));
  endtask

  task automatic compare_result();
    estimate_t e;
    if (estimate_q.size() == 0) begin
      report_mismatch("result transfer with no result pending");
    end else begin
      e = estimate_q.pop_front();
      n_results++;
      if (e.live) n_live++;
      check_field("target_valid", {{(CoordBits-1){1'b0}}, e.live},
                  {{(CoordBits-1){1'b0}}, target_valid});
      check_field("estimate_x", e.x, estimate_x);
      check_field("estimate_y", e.y, estimate_y);
      check_field("estimate_vx", e.vx, estimate_vx);
      check_field("estimate_vy", e.vy, estimate_vy);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      estimate_q.delete();
      alpha = RstPosGain;
      beta = RstVelGain;
      decay = RstDecay;
      gate = RstGate;
      miss_lim = RstMissLim;
      tracking = 1'b0;
      frame_open = 1'b0;
      pos_x = 0;
      pos_y = 0;
      vel_x = 0;
      vel_y = 0;
      best_x = 0;
      best_y = 0;
      best_d = 0;
      misses = 0;
    end else begin
      if (psel && penable && pwrite && pready) set_register(paddr[AddrBits-1:2], pwdata);
      if (out_valid && !out_stall) compare_result();
      if (in_valid && !in_stall)
        take_item(has_point, point_x, point_y, last_of_frame, self_x, self_y);
    end
    // published with nonblocking assignments so readers never race the update
    fail_count <= errors;
    pending <= estimate_q.size();
    results_checked <= n_results;
    live_checked <= n_live;
    tracks_started <= n_starts;
  end

endmodule

FILE: sim/tb_alpha_beta_target_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_alpha_beta_target_tracker: stimulus and verdict for the tracker
// Directed frames at the reset settings, then random frames around a moving
// target under several register settings, with random gaps on both channels,
// a long output hold-off and a gap-free stretch.
// ----------------------------------------------------------------------------

module tb_alpha_beta_target_tracker;
  import abt_pkg::*;

  localparam int ItemsPerPhase = 275;
  localparam int SettleCycles  = 20;
  localparam int HoldOffCycles = 400;
  localparam int WatchdogLimit = 20000;
  localparam int CoordHi       = (1 <<< (CoordBits - 1)) - 1;
  localparam int CoordLo       = -CoordHi - 1;

  logic                clk;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [DataBits-1:0] pwdata = '0;
  logic [DataBits-1:0] prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                has_point = 1'b0;
  coord_t              point_x = '0;
  coord_t              point_y = '0;
  logic                last_of_frame = 1'b0;
  coord_t              self_x = '0;
  coord_t              self_y = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                target_valid;
  coord_t              estimate_x, estimate_y, estimate_vx, estimate_vy;

  int fail_count, pending, results_checked, live_checked, tracks_started;

  int items_sent = 0;
  int settings_used = 1;
  int tgt_x = 0, tgt_y = 0, tgt_vx = 0, tgt_vy = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  alpha_beta_target_tracker uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .has_point(has_point), .point_x(point_x), .point_y(point_y),
    .last_of_frame(last_of_frame), .self_x(self_x), .self_y(self_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .target_valid(target_valid), .estimate_x(estimate_x), .estimate_y(estimate_y),
    .estimate_vx(estimate_vx), .estimate_vy(estimate_vy)
  );

  abt_track_checker tracker_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .has_point(has_point), .point_x(point_x), .point_y(point_y),
    .last_of_frame(last_of_frame), .self_x(self_x), .self_y(self_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .target_valid(target_valid), .estimate_x(estimate_x), .estimate_y(estimate_y),
    .estimate_vx(estimate_vx), .estimate_vy(estimate_vy),
    .fail_count(fail_count), .pending(pending), .results_checked(results_checked),
    .live_checked(live_checked), .tracks_started(tracks_started)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic coord_t to_coord(input int v);
    if (v > CoordHi) return coord_t'(CoordHi);
    if (v < CoordLo) return coord_t'(CoordLo);
    return coord_t'(v);
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t around(input int c, input int spread);
    return to_coord(c + int'($urandom_range(2 * spread)) - spread);
  endfunction

  task automatic send_item(input logic hp, input coord_t px, py, input logic last,
                           input coord_t sx, sy);
    if (!steady) begin
      while ($urandom_range(99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    has_point <= hp;
    point_x <= px;
    point_y <= py;
    last_of_frame <= last;
    self_x <= sx;
    self_y <= sy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // empty-frame marker with junk in the ignored fields
  task automatic send_empty();
    send_item(1'b0, any_coord(), any_coord(), logic'($urandom_range(1)),
              any_coord(), any_coord());
  endtask

  task automatic write_reg(input logic [RegIdxBits-1:0] idx, input logic [DataBits-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input int pg, vg, dc, input logic [31:0] gate, input int ml);
    write_reg(REG_POS_GAIN, pg);
    write_reg(REG_VEL_GAIN, vg);
    write_reg(REG_DECAY, dc);
    write_reg(REG_GATE, gate);
    write_reg(REG_MISS_LIM, ml);
    settings_used++;
  endtask

  // wait until every result is in, then let frames without a result drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic move_target();
    int spd;
    if ($urandom_range(99) < 3) begin
      case ($urandom_range(2))
        0: spd = 0;
        1: spd = 64;
        default: spd = 2000;
      endcase
      tgt_x = any_coord();
      tgt_y = any_coord();
      tgt_vx = int'($urandom_range(2 * spd)) - spd;
      tgt_vy = int'($urandom_range(2 * spd)) - spd;
    end
    tgt_x += tgt_vx;
    tgt_y += tgt_vy;
    if (tgt_x > CoordHi || tgt_x < CoordLo) begin
      tgt_vx = -tgt_vx;
      tgt_x = to_coord(tgt_x);
    end
    if (tgt_y > CoordHi || tgt_y < CoordLo) begin
      tgt_vy = -tgt_vy;
      tgt_y = to_coord(tgt_y);
    end
  endtask

  task automatic send_frame();
    int kind, npts, spread, ending;
    logic last;
    coord_t sx, sy;
    kind = $urandom_range(99);
    move_target();
    if (kind < 14) begin
      // runs of empty frames, long ones drive coasting into a drop
      repeat ($urandom_range(kind < 3 ? 17 : 2, 1)) send_empty();
    end else begin
      npts = $urandom_range(kind > 94 ? 8 : 3, 1);
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: spread = 200;
        6, 7, 8: spread = 1000;
        default: spread = 8000;
      endcase
      // 0: closed by an empty marker, 1: left open into the next frame, else closed by the last point
      ending = $urandom_range(9);
      if ($urandom_range(1)) begin
        sx = around(tgt_x, 3000);
        sy = around(tgt_y, 3000);
      end else begin
        sx = any_coord();
        sy = any_coord();
      end
      for (int i = 0; i < npts; i++) begin
        last = (i == npts - 1) && (ending > 1);
        if ($urandom_range(99) < 75)
          send_item(1'b1, around(tgt_x, spread), around(tgt_y, spread), last, sx, sy);
        else
          send_item(1'b1, any_coord(), any_coord(), last, sx, sy);
      end
      if (ending == 0) send_empty();
    end
  endtask

  task automatic run_phase();
    int goal;
    goal = items_sent + ItemsPerPhase;
    while (items_sent < goal) send_frame();
  endtask

  // result side: one long hold-off so the block backs up, then a clean stretch
  initial begin : receiver
    int quiet_left;
    bit held;
    quiet_left = 0;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
        quiet_left = 1500;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < 32);
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout: no transfer for %0d cycles, %0d results pending",
                 idle_cycles, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: empty frame with no track
    send_empty();
    // equal-distance point does not replace the first, nearer one does
    send_item(1'b1, 16'sd100, 16'sd0, 1'b0, 16'sd0, 16'sd0);
    send_item(1'b1, 16'sd0, -16'sd100, 1'b0, 16'sd0, 16'sd0);
    send_item(1'b1, 16'sd50, 16'sd50, 1'b1, 16'sd0, 16'sd0);
    // match, own position ignored while tracking
    send_item(1'b1, 16'sd60, 16'sd55, 1'b1, coord_t'(CoordLo), coord_t'(CoordHi));
    // gating miss
    send_item(1'b1, 16'sd20000, 16'sd20000, 1'b1, 16'sd0, 16'sd0);
    // frame closed by an empty marker
    send_item(1'b1, coord_t'(CoordLo), coord_t'(CoordLo), 1'b0, 16'sd0, 16'sd0);
    send_item(1'b1, 16'sd70, 16'sd60, 1'b0, 16'sd0, 16'sd0);
    send_empty();
    // coast, far miss, then coast until the miss limit drops the track
    send_empty();
    send_item(1'b1, coord_t'(CoordHi), coord_t'(CoordHi), 1'b1, 16'sd0, 16'sd0);
    repeat (10) send_empty();
    send_empty();
    // start at a corner, exact hit, then a near one
    send_item(1'b1, coord_t'(CoordLo), coord_t'(CoordHi), 1'b1,
              coord_t'(CoordHi), coord_t'(CoordLo));
    send_item(1'b1, coord_t'(CoordLo), coord_t'(CoordHi), 1'b1, 16'sd0, 16'sd0);
    send_item(1'b1, -16'sd32700, 16'sd32700, 1'b1, 16'sd0, 16'sd0);
    settle();

    apply_setting(256, 256, 256, 32'hFFFF_FFFF, 15);
    hold_req = 1'b1;
    run_phase();
    settle();

    apply_setting(0, 0, 0, 32'd0, 1);
    run_phase();
    settle();

    apply_setting($urandom_range(256), $urandom_range(256), $urandom_range(256),
                  $urandom_range(1 << 24, 1 << 14), 0);
    steady = 1'b1;
    run_phase();
    steady = 1'b0;
    settle();

    apply_setting($urandom_range(511), $urandom_range(511), $urandom_range(511),
                  $urandom, $urandom_range(15));
    run_phase();
    settle();

    apply_setting(RstPosGain, RstVelGain, RstDecay, RstGate, RstMissLim);
    run_phase();
    settle();

    apply_setting($urandom_range(256), $urandom_range(256), $urandom_range(256),
                  $urandom_range(1 << 22), $urandom_range(15, 1));
    run_phase();
    settle();

    $display("sent %0d input items under %0d register settings", items_sent, settings_used);
    $display("checked %0d results, %0d of them live estimates, %0d tracks started",
             results_checked, live_checked, tracks_started);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
